// File: sv/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the fixed-point calculator
// Operation, trig and status codes, field widths and the link between the
// sequencer and the serial multiply/divide unit.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int KIND_W = 3;
    localparam int DATA_W = 32;
    localparam int EXP_W  = 8;
    localparam int TSEL_W = 2;
    localparam int ST_W   = 2;
    localparam int WIDE_W = 64;

    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POW  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TRIG = 3'd5;

    localparam logic [TSEL_W-1:0] TRIG_NONE = 2'd0;
    localparam logic [TSEL_W-1:0] TRIG_SIN  = 2'd1;
    localparam logic [TSEL_W-1:0] TRIG_COS  = 2'd2;
    localparam logic [TSEL_W-1:0] TRIG_TAN  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT     = 2'd3;

    // internal clamp of the series and of every product: +-(2^62 - 1)
    localparam logic signed [WIDE_W-1:0] WIDE_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic start;   // one-cycle pulse, operands valid
        logic div;     // 1: quotient, 0: scaled product
    } t_mdu_cmd;

    typedef struct packed {
        logic done;    // one-cycle pulse, result valid
        logic sat;     // product clamped to the internal limit
    } t_mdu_rsp;

endpackage

// File: sv/fpc_if.sv
// ----------------------------------------------------------------------------
// fpc_if: request and response channels of the fixed-point calculator
// Valid/ready channels; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface fpc_req_if;
    logic                                valid;
    logic                                ready;
    logic [fpc_pkg::KIND_W-1:0]          kind;
    logic signed [fpc_pkg::DATA_W-1:0]   operand_a;
    logic signed [fpc_pkg::DATA_W-1:0]   operand_b;
    logic signed [fpc_pkg::EXP_W-1:0]    exponent;
    logic [fpc_pkg::TSEL_W-1:0]          trig_select;

    modport source (output valid, kind, operand_a, operand_b, exponent, trig_select,
                    input ready);
    modport sink   (input valid, kind, operand_a, operand_b, exponent, trig_select,
                    output ready);
endinterface

interface fpc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [fpc_pkg::DATA_W-1:0]   result;
    logic [fpc_pkg::ST_W-1:0]            status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

// File: sv/fpc_mdu.sv
// ----------------------------------------------------------------------------
// fpc_mdu: bit-serial signed multiply / divide unit
// Shift-add product with round-to-nearest scaling, or restoring division
// truncated toward zero; one bit per cycle.
// ----------------------------------------------------------------------------
module fpc_mdu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fpc_pkg::t_mdu_cmd                    i_cmd,
    input  logic signed [fpc_pkg::WIDE_W-1:0]    i_opa,
    input  logic signed [fpc_pkg::WIDE_W-1:0]    i_opb,
    output fpc_pkg::t_mdu_rsp                    o_rsp,
    output logic signed [fpc_pkg::WIDE_W-1:0]    o_res
);

    localparam int W  = fpc_pkg::WIDE_W;
    localparam int CW = $clog2(W);
    localparam logic [W:0] HALF = (W+1)'(1) << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } t_mstate;

    t_mstate        r_state;
    logic [CW-1:0]  r_cnt;
    logic           r_div;
    logic           r_neg;
    logic [W-1:0]   r_md;
    logic [W-1:0]   r_hi;
    logic [W-1:0]   r_lo;
    logic           r_done;
    logic           r_sat;
    logic signed [W-1:0] r_res;

    logic [W:0]     w_madd;
    logic [W:0]     w_trial;
    logic           w_ge;
    logic [W:0]     w_rnd;
    logic           w_ovf;
    logic [W-1:0]   w_mag;

    // one step of each algorithm
    assign w_madd  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_md} : '0);
    assign w_trial = {r_hi, r_lo[W-1]} - {1'b0, r_md};
    assign w_ge    = ~w_trial[W];

    // round the product, then scale; any carry past 64 bits clamps
    assign w_rnd = {1'b0, r_lo} + HALF;
    assign w_ovf = (|r_hi) | w_rnd[W];
    always_comb begin
        if (r_div) begin
            w_mag = r_lo;
        end else if (w_ovf) begin
            w_mag = W'(fpc_pkg::WIDE_LIM);
        end else begin
            w_mag = W'(w_rnd[W-1:FRAC_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_cmd.start) begin
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    if (r_cnt == '0) begin
                        r_state <= M_FIN;
                    end
                end
                M_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_div <= i_cmd.div;
                r_neg <= i_opa[W-1] ^ i_opb[W-1];
                r_md  <= i_opb[W-1] ? W'(-i_opb) : W'(i_opb);
                r_lo  <= i_opa[W-1] ? W'(-i_opa) : W'(i_opa);
                r_hi  <= '0;
                r_cnt <= CW'(W - 1);
            end
            M_RUN: begin
                r_cnt <= r_cnt - 1'b1;
                if (r_div) begin
                    r_hi <= w_ge ? w_trial[W-1:0] : {r_hi[W-2:0], r_lo[W-1]};
                    r_lo <= {r_lo[W-2:0], w_ge};
                end else begin
                    r_hi <= w_madd[W:1];
                    r_lo <= {w_madd[0], r_lo[W-1:1]};
                end
            end
            M_FIN: begin
                r_res <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                r_sat <= ~r_div & w_ovf;
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_res      = r_res;

endmodule

// File: sv/fixed_point_calculator_with_trig_core.sv
// ----------------------------------------------------------------------------
// fixed_point_calculator_with_trig_core: Q-format calculator with trig
// Add, subtract, multiply, divide, integer power and Taylor-series
// sine / cosine / tangent on signed fixed-point words.
// ----------------------------------------------------------------------------
// One request word in, one response word out, one request at a time. All
// multiplies and divides run on a single bit-serial unit that retires one
// bit per cycle. Add and subtract do not use the unit; multiply and a
// nonzero divide use it once; power runs one multiply per unit of exponent
// (up to 127); sine or cosine take one squaring plus a multiply and a
// divide for each of the TAYLOR_TERMS-1 series steps; tangent runs both
// series on the same squaring and a final divide. A finished response
// waits in the output register until it is taken; the next request is
// accepted once the core is back in idle.
// ----------------------------------------------------------------------------
module fixed_point_calculator_with_trig_core #(
    parameter int TAYLOR_TERMS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fpc_req_if.sink  i_req,
    fpc_rsp_if.source o_rsp
);

    localparam int W  = fpc_pkg::WIDE_W;
    localparam int DW = fpc_pkg::DATA_W;
    localparam int KW = $clog2(TAYLOR_TERMS);
    localparam int DDW = 2 * KW + 2;
    localparam logic signed [W-1:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic [KW-1:0] K_LAST = KW'(TAYLOR_TERMS - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DISP = 9'b000000010,
        S_SQ   = 9'b000000100,
        S_TMUL = 9'b000001000,
        S_TDIV = 9'b000010000,
        S_PMUL = 9'b000100000,
        S_FMUL = 9'b001000000,
        S_FDIV = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    // does v overflow a signed data word
    function automatic logic f_ovf32(input logic signed [W-1:0] v);
        return !((&v[W-1:DW-1]) || !(|v[W-1:DW-1]));
    endfunction

    function automatic logic signed [DW-1:0] f_clamp32(input logic signed [W-1:0] v);
        logic signed [DW-1:0] c;
        if (f_ovf32(v)) begin
            c = v[W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            c = v[DW-1:0];
        end
        return c;
    endfunction

    t_state n_state;
    t_state r_state;

    // request fields
    logic [fpc_pkg::KIND_W-1:0]        r_kind, n_kind;
    logic signed [DW-1:0]              r_a, n_a;
    logic signed [DW-1:0]              r_b, n_b;
    logic signed [fpc_pkg::EXP_W-1:0]  r_e, n_e;
    logic [fpc_pkg::TSEL_W-1:0]        r_tsel, n_tsel;

    // working state
    logic                   r_cos, n_cos;
    logic                   r_sat, n_sat;
    logic [fpc_pkg::ST_W-1:0] r_st, n_st;
    logic signed [DW-1:0]   r_res, n_res;
    logic signed [DW-1:0]   r_sval, n_sval;
    logic signed [W-1:0]    r_x2, n_x2;
    logic signed [W-1:0]    r_sum, n_sum;
    logic [KW-1:0]          r_k, n_k;
    logic [fpc_pkg::EXP_W-2:0] r_pcnt, n_pcnt;

    // serial unit hand-off
    logic signed [W-1:0]    r_opa, n_opa;
    logic signed [W-1:0]    r_opb, n_opb;
    logic                   r_div, n_div;
    logic                   r_start, n_start;

    // output register
    logic                   r_ov, n_ov;
    logic signed [DW-1:0]   r_ores, n_ores;
    logic [fpc_pkg::ST_W-1:0] r_ost, n_ost;

    fpc_pkg::t_mdu_cmd      w_cmd;
    fpc_pkg::t_mdu_rsp      w_mrsp;
    logic signed [W-1:0]    w_mres;

    logic signed [W-1:0]    w_a64, w_b64;
    logic signed [DW:0]     w_addsub;
    logic signed [W-1:0]    w_nterm;
    logic [KW:0]            w_tk, w_odd;
    logic [DDW-1:0]         w_d;
    logic signed [W:0]      w_sum65;
    logic signed [W-1:0]    w_wsum;
    logic                   w_wsat;
    logic signed [DW-1:0]   w_v32;
    logic                   w_accept;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_a64    = W'(r_a);
    assign w_b64    = W'(r_b);
    assign w_addsub = (r_kind == fpc_pkg::KIND_SUB) ? ((DW+1)'(r_a) - (DW+1)'(r_b))
                                                    : ((DW+1)'(r_a) + (DW+1)'(r_b));
    assign w_nterm  = -w_mres;

    // series divisor: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
    assign w_tk  = {r_k, 1'b0};
    assign w_odd = r_cos ? (w_tk - (KW+1)'(1)) : (w_tk + (KW+1)'(1));
    assign w_d   = DDW'(w_tk) * DDW'(w_odd);

    // running sum, clamped to the internal limit
    assign w_sum65 = (W+1)'(r_sum) + (W+1)'(w_mres);
    always_comb begin
        w_wsat = 1'b0;
        w_wsum = w_sum65[W-1:0];
        if (w_sum65 > (W+1)'(fpc_pkg::WIDE_LIM)) begin
            w_wsat = 1'b1;
            w_wsum = fpc_pkg::WIDE_LIM;
        end else if (w_sum65 < -((W+1)'(fpc_pkg::WIDE_LIM))) begin
            w_wsat = 1'b1;
            w_wsum = -fpc_pkg::WIDE_LIM;
        end
    end
    assign w_v32 = f_clamp32(w_wsum);

    assign w_cmd.start = r_start;
    assign w_cmd.div   = r_div;

    fpc_mdu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_opa   (r_opa),
        .i_opb   (r_opb),
        .o_rsp   (w_mrsp),
        .o_res   (w_mres)
    );

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_a     = r_a;
        n_b     = r_b;
        n_e     = r_e;
        n_tsel  = r_tsel;
        n_cos   = r_cos;
        n_sat   = r_sat;
        n_st    = r_st;
        n_res   = r_res;
        n_sval  = r_sval;
        n_x2    = r_x2;
        n_sum   = r_sum;
        n_k     = r_k;
        n_pcnt  = r_pcnt;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_div   = r_div;
        n_start = 1'b0;
        n_ores  = r_ores;
        n_ost   = r_ost;
        // drop the response word once taken
        n_ov    = r_ov && !o_rsp.ready;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_req.kind;
                    n_a     = i_req.operand_a;
                    n_b     = i_req.operand_b;
                    n_e     = i_req.exponent;
                    n_tsel  = i_req.trig_select;
                    n_sat   = 1'b0;
                    n_st    = fpc_pkg::ST_OK;
                    n_res   = '0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_kind)
                    fpc_pkg::KIND_ADD, fpc_pkg::KIND_SUB: begin
                        n_res   = f_clamp32(W'(w_addsub));
                        n_sat   = f_ovf32(W'(w_addsub));
                        n_state = S_DONE;
                    end
                    fpc_pkg::KIND_MUL: begin
                        n_opa   = w_a64;
                        n_opb   = w_b64;
                        n_div   = 1'b0;
                        n_start = 1'b1;
                        n_state = S_FMUL;
                    end
                    fpc_pkg::KIND_DIV: begin
                        if (r_b == '0) begin
                            n_st    = fpc_pkg::ST_DIVZERO;
                            n_state = S_DONE;
                        end else begin
                            n_opa   = w_a64 <<< FRAC_BITS;
                            n_opb   = w_b64;
                            n_div   = 1'b1;
                            n_start = 1'b1;
                            n_state = S_FDIV;
                        end
                    end
                    fpc_pkg::KIND_POW: begin
                        n_res = ONE[DW-1:0];
                        if (r_e[fpc_pkg::EXP_W-1] || r_e == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_pcnt  = r_e[fpc_pkg::EXP_W-2:0];
                            n_opa   = ONE;
                            n_opb   = w_a64;
                            n_div   = 1'b0;
                            n_start = 1'b1;
                            n_state = S_PMUL;
                        end
                    end
                    fpc_pkg::KIND_TRIG: begin
                        if (r_tsel == fpc_pkg::TRIG_NONE) begin
                            n_st    = fpc_pkg::ST_INVALID;
                            n_state = S_DONE;
                        end else begin
                            // tangent runs the sine pass first
                            n_cos   = (r_tsel == fpc_pkg::TRIG_COS);
                            n_opa   = w_a64;
                            n_opb   = w_a64;
                            n_div   = 1'b0;
                            n_start = 1'b1;
                            n_state = S_SQ;
                        end
                    end
                    default: begin
                        n_st    = fpc_pkg::ST_INVALID;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SQ: begin
                if (w_mrsp.done) begin
                    n_x2    = w_mres;
                    n_sat   = r_sat | w_mrsp.sat;
                    n_sum   = r_cos ? ONE : w_a64;
                    n_k     = KW'(1);
                    n_opa   = r_cos ? ONE : w_a64;
                    n_opb   = w_mres;
                    n_div   = 1'b0;
                    n_start = 1'b1;
                    n_state = S_TMUL;
                end
            end
            S_TMUL: begin
                if (w_mrsp.done) begin
                    // negate the product, then divide by the factorial step
                    n_sat   = r_sat | w_mrsp.sat;
                    n_opa   = w_nterm;
                    n_opb   = W'(w_d);
                    n_div   = 1'b1;
                    n_start = 1'b1;
                    n_state = S_TDIV;
                end
            end
            S_TDIV: begin
                if (w_mrsp.done) begin
                    n_sum  = w_wsum;
                    n_sat  = r_sat | w_wsat;
                    if (r_k == K_LAST) begin
                        n_sat = r_sat | w_wsat | f_ovf32(w_wsum);
                        if (r_tsel != fpc_pkg::TRIG_TAN) begin
                            n_res   = w_v32;
                            n_state = S_DONE;
                        end else if (!r_cos) begin
                            // hold the sine, start the cosine pass on the same square
                            n_sval  = w_v32;
                            n_cos   = 1'b1;
                            n_sum   = ONE;
                            n_k     = KW'(1);
                            n_opa   = ONE;
                            n_opb   = r_x2;
                            n_div   = 1'b0;
                            n_start = 1'b1;
                            n_state = S_TMUL;
                        end else if (w_v32 == '0) begin
                            n_st    = fpc_pkg::ST_DIVZERO;
                            n_res   = '0;
                            n_state = S_DONE;
                        end else begin
                            n_opa   = W'(r_sval) <<< FRAC_BITS;
                            n_opb   = W'(w_v32);
                            n_div   = 1'b1;
                            n_start = 1'b1;
                            n_state = S_FDIV;
                        end
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_opa   = w_mres;
                        n_opb   = r_x2;
                        n_div   = 1'b0;
                        n_start = 1'b1;
                        n_state = S_TMUL;
                    end
                end
            end
            S_PMUL: begin
                if (w_mrsp.done) begin
                    // the clamped value feeds the next multiply
                    n_res  = f_clamp32(w_mres);
                    n_sat  = r_sat | w_mrsp.sat | f_ovf32(w_mres);
                    n_pcnt = r_pcnt - 1'b1;
                    if (r_pcnt == (fpc_pkg::EXP_W-1)'(1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_opa   = W'(f_clamp32(w_mres));
                        n_opb   = w_a64;
                        n_div   = 1'b0;
                        n_start = 1'b1;
                    end
                end
            end
            S_FMUL, S_FDIV: begin
                if (w_mrsp.done) begin
                    n_res   = f_clamp32(w_mres);
                    n_sat   = r_sat | w_mrsp.sat | f_ovf32(w_mres);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // advance into the output register when it is free
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_ores  = (r_st == fpc_pkg::ST_INVALID || r_st == fpc_pkg::ST_DIVZERO)
                              ? '0 : r_res;
                    n_ost   = (r_st == fpc_pkg::ST_OK && r_sat) ? fpc_pkg::ST_SAT : r_st;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_a    <= n_a;
        r_b    <= n_b;
        r_e    <= n_e;
        r_tsel <= n_tsel;
        r_cos  <= n_cos;
        r_sat  <= n_sat;
        r_st   <= n_st;
        r_res  <= n_res;
        r_sval <= n_sval;
        r_x2   <= n_x2;
        r_sum  <= n_sum;
        r_k    <= n_k;
        r_pcnt <= n_pcnt;
        r_opa  <= n_opa;
        r_opb  <= n_opb;
        r_div  <= n_div;
        r_ores <= n_ores;
        r_ost  <= n_ost;
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_ov;
    assign o_rsp.result = r_ores;
    assign o_rsp.status = r_ost;

    // the serial unit only answers while the sequencer waits for it
    a_mdu_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mrsp.done |-> (r_state == S_SQ || r_state == S_TMUL || r_state == S_TDIV ||
                         r_state == S_PMUL || r_state == S_FMUL || r_state == S_FDIV))
        else $error("serial unit finished with no operation pending");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == fpc_pkg::ST_INVALID ||
                         o_rsp.status == fpc_pkg::ST_DIVZERO)) |-> (o_rsp.result == '0))
        else $error("error response carries a nonzero result");

    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DISP))
        else $error("accepted word not dispatched");

    a_pow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PMUL) |-> (r_pcnt != '0))
        else $error("power loop running with zero count");

    a_series_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TDIV) |-> (r_k != '0))
        else $error("series step index at zero");

endmodule

// File: tb/tb_fixed_point_calculator_with_trig_core.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_calculator_with_trig_core: self-checking calculator bench
// Directed and random requests for every operation, with bursty requests and
// a stalling response side; each response word is checked against a
// bit-exact fixed-point model kept in the bench.
// ----------------------------------------------------------------------------
module tb_fixed_point_calculator_with_trig_core;

    localparam int FRAC = 16;
    localparam int TERMS = 16;
    localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC;
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;
    localparam logic [63:0] LIM_U = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [31:0] PI_Q = 32'sd205887;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd102944;

    typedef struct packed {
        logic signed [31:0]        result;
        logic [fpc_pkg::ST_W-1:0]  status;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpc_req_if req_if ();
    fpc_rsp_if rsp_if ();

    fixed_point_calculator_with_trig_core #(
        .TAYLOR_TERMS(TERMS),
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if),
        .o_rsp(rsp_if)
    );

    always #5 i_clk = ~i_clk;

    t_answer answers_due[$];
    int      errors = 0;
    bit      sat_seen;   // set by the model helpers whenever a clamp fires
    int      burst_left = 0;

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    // Scaled product, rounded to nearest with ties away from zero, clamped to
    // the internal 62-bit limit.
    function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic [63:0]  ua, ub, r, half;
        logic [127:0] p;
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        half = 64'd1 << (FRAC - 1);
        p    = {64'd0, ua} * {64'd0, ub};
        if (p > {64'd0, 64'hFFFF_FFFF_FFFF_FFFF - half}) begin
            r = LIM_U;
            sat_seen = 1'b1;
        end else begin
            r = (p[63:0] + half) >> FRAC;
            if (r > LIM_U) begin
                r = LIM_U;
                sat_seen = 1'b1;
            end
        end
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] clamp_wide(input logic signed [63:0] v);
        if (v > $signed(LIM_U)) begin
            sat_seen = 1'b1;
            return $signed(LIM_U);
        end
        if (v < -$signed(LIM_U)) begin
            sat_seen = 1'b1;
            return -$signed(LIM_U);
        end
        return v;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > MAX32) begin
            sat_seen = 1'b1;
            return MAX32;
        end
        if (v < MIN32) begin
            sat_seen = 1'b1;
            return MIN32;
        end
        return v;
    endfunction

    // Taylor series; each term grows out of the previous one.
    function automatic logic signed [63:0] taylor(input logic signed [63:0] x,
                                                  input bit is_cos);
        logic signed [63:0] x2, term, sum, d;
        x2   = q_mul(x, x);
        term = is_cos ? Q_ONE : x;
        sum  = term;
        for (int k = 1; k < TERMS; k++) begin
            d    = is_cos ? 64'(2 * k - 1) * 64'(2 * k) : 64'(2 * k) * 64'(2 * k + 1);
            term = -q_mul(term, x2);
            term = term / d;   // truncates toward zero
            sum  = clamp_wide(sum + term);
        end
        return sum;
    endfunction

    function automatic t_answer predict_answer(input logic [fpc_pkg::KIND_W-1:0] kind,
                                               input logic signed [31:0] a32,
                                               input logic signed [31:0] b32,
                                               input logic signed [7:0] ex,
                                               input logic [fpc_pkg::TSEL_W-1:0] tsel);
        logic signed [63:0]        a, b, res, s, c;
        logic [fpc_pkg::ST_W-1:0]  st;
        t_answer                   ans;
        a   = 64'(a32);
        b   = 64'(b32);
        res = '0;
        st  = fpc_pkg::ST_OK;
        sat_seen = 1'b0;
        case (kind)
            fpc_pkg::KIND_ADD: res = clamp32(a + b);
            fpc_pkg::KIND_SUB: res = clamp32(a - b);
            fpc_pkg::KIND_MUL: res = clamp32(q_mul(a, b));
            fpc_pkg::KIND_DIV: begin
                if (b == 0) st = fpc_pkg::ST_DIVZERO;
                else res = clamp32((a * Q_ONE) / b);
            end
            fpc_pkg::KIND_POW: begin
                res = Q_ONE;
                for (int i = 0; i < ex; i++) res = clamp32(q_mul(res, a));
            end
            fpc_pkg::KIND_TRIG: begin
                case (tsel)
                    fpc_pkg::TRIG_SIN: res = clamp32(taylor(a, 1'b0));
                    fpc_pkg::TRIG_COS: res = clamp32(taylor(a, 1'b1));
                    fpc_pkg::TRIG_TAN: begin
                        s = clamp32(taylor(a, 1'b0));
                        c = clamp32(taylor(a, 1'b1));
                        if (c == 0) st = fpc_pkg::ST_DIVZERO;
                        else res = clamp32((s * Q_ONE) / c);
                    end
                    default: st = fpc_pkg::ST_INVALID;
                endcase
            end
            default: st = fpc_pkg::ST_INVALID;
        endcase
        if (st == fpc_pkg::ST_OK && sat_seen) st = fpc_pkg::ST_SAT;
        if (st == fpc_pkg::ST_INVALID || st == fpc_pkg::ST_DIVZERO) res = '0;
        ans.result = res[31:0];
        ans.status = st;
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Request side: bursts of back-to-back words separated by random gaps
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [fpc_pkg::KIND_W-1:0] kind,
                                input logic signed [31:0] a,
                                input logic signed [31:0] b,
                                input logic signed [7:0] ex,
                                input logic [fpc_pkg::TSEL_W-1:0] tsel);
        int gap;
        if (burst_left == 0) begin
            // drop valid for a random gap, which may be empty, then start a new burst
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.operand_a   <= a;
        req_if.operand_b   <= b;
        req_if.exponent    <= ex;
        req_if.trig_select <= tsel;
        // hold the word until the core takes it
        do @(posedge i_clk); while (!req_if.ready);
        answers_due.push_back(predict_answer(kind, a, b, ex, tsel));
        burst_left--;
    endtask

    // ------------------------------------------------------------------------
    // Response side: stall pattern switches between open, light and heavy
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;

    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 400);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase

        // check each word taken at this edge against the oldest prediction
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
                $error("unexpected response word: result %0d status %0d",
                       rsp_if.result, rsp_if.status);
                errors++;
            end else begin
                exp_ans = answers_due.pop_front();
                if (rsp_if.result !== exp_ans.result) begin
                    $error("result: expected %0d actual %0d", exp_ans.result, rsp_if.result);
                    errors++;
                end
                if (rsp_if.status !== exp_ans.status) begin
                    $error("status: expected %0d actual %0d", exp_ans.status, rsp_if.status);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_add_sub();
        send_request(fpc_pkg::KIND_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'sd0,
                     fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_ADD, 32'sh8000_0000, 32'sh8000_0000, 8'sd0,
                     fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_SUB, 32'sh8000_0000, 32'sd1, 8'sd0, fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_SUB, 32'sd0, 32'sh8000_0000, 8'sd0, fpc_pkg::TRIG_NONE);
    endtask

    task automatic test_mul_div();
        send_request(fpc_pkg::KIND_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'sd0,
                     fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_MUL, 32'sh8000_0000, 32'sh8000_0000, 8'sd0,
                     fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_MUL, -32'sd98304, 32'sd1, 8'sd0,
                     fpc_pkg::TRIG_NONE); // round tie
        send_request(fpc_pkg::KIND_DIV, 32'sd12345, 32'sd0, 8'sd0, fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_DIV, 32'sh8000_0000, -32'sd65536, 8'sd0,
                     fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_DIV, -32'sd7, 32'sd3, 8'sd0, fpc_pkg::TRIG_NONE);
    endtask

    task automatic test_power();
        send_request(fpc_pkg::KIND_POW, 32'sd131072, 32'sd0, -8'sd128,
                     fpc_pkg::TRIG_NONE); // negative power
        send_request(fpc_pkg::KIND_POW, 32'sd131072, 32'sd0, 8'sd0, fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_POW, -32'sd98304, 32'sd0, 8'sd5, fpc_pkg::TRIG_NONE);
        send_request(fpc_pkg::KIND_POW, 32'sd131072, 32'sd0, 8'sd127,
                     fpc_pkg::TRIG_NONE); // overflow
    endtask

    task automatic test_trig();
        send_request(fpc_pkg::KIND_TRIG, 32'sd0, 32'sd0, 8'sd0, fpc_pkg::TRIG_SIN);
        send_request(fpc_pkg::KIND_TRIG, 32'sd65536, 32'sd0, 8'sd0, fpc_pkg::TRIG_COS);
        send_request(fpc_pkg::KIND_TRIG, HALF_PI_Q, 32'sd0, 8'sd0, fpc_pkg::TRIG_TAN);
        send_request(fpc_pkg::KIND_TRIG, -PI_Q, 32'sd0, 8'sd0, fpc_pkg::TRIG_SIN);
        send_request(fpc_pkg::KIND_TRIG, 32'sh7FFF_FFFF, 32'sd0, 8'sd0,
                     fpc_pkg::TRIG_COS); // no range reduction
        send_request(fpc_pkg::KIND_TRIG, 32'sh8000_0000, 32'sd0, 8'sd0, fpc_pkg::TRIG_TAN);
    endtask

    task automatic test_invalid();
        send_request(fpc_pkg::KIND_TRIG, 32'sd65536, 32'sd0, 8'sd0, fpc_pkg::TRIG_NONE);
        send_request(3'd6, 32'sd1, 32'sd2, 8'sd3, fpc_pkg::TRIG_SIN);
        send_request(3'd7, -32'sd1, 32'sd0, -8'sd1, fpc_pkg::TRIG_TAN);
    endtask

    // ------------------------------------------------------------------------
    // Random mix: mostly sane operand ranges, some full-width noise
    // ------------------------------------------------------------------------
    task automatic test_random(input int n_words);
        logic [fpc_pkg::KIND_W-1:0]   kind;
        logic signed [31:0]           a, b;
        logic signed [7:0]            ex;
        logic [fpc_pkg::TSEL_W-1:0]   tsel;
        int                           pick;
        for (int n = 0; n < n_words; n++) begin
            pick = $urandom_range(0, 99);
            kind = pick < 12 ? fpc_pkg::KIND_ADD : pick < 22 ? fpc_pkg::KIND_SUB :
                   pick < 34 ? fpc_pkg::KIND_MUL : pick < 48 ? fpc_pkg::KIND_DIV :
                   pick < 64 ? fpc_pkg::KIND_POW : pick < 96 ? fpc_pkg::KIND_TRIG :
                   3'($urandom_range(6, 7));
            a    = $urandom;
            b    = $urandom;
            ex   = 8'($urandom);
            tsel = $urandom_range(0, 9) == 0 ? fpc_pkg::TRIG_NONE
                                             : fpc_pkg::TSEL_W'($urandom_range(1, 3));
            if ($urandom_range(0, 1) == 0) begin
                a = $signed(32'($urandom_range(0, 1 << 20))) - (32'sd1 << 19);
                b = $signed(32'($urandom_range(0, 1 << 20))) - (32'sd1 << 19);
            end
            if (kind == fpc_pkg::KIND_DIV && $urandom_range(0, 9) == 0) b = '0;
            if (kind == fpc_pkg::KIND_POW) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    ex = 8'($urandom_range(0, 12));
                    a  = $signed(32'($urandom_range(0, 1 << 18))) - (32'sd1 << 17);
                end else if (pick == 8) begin
                    ex = -$signed(8'($urandom_range(1, 128)));
                end
            end
            if (kind == fpc_pkg::KIND_TRIG && $urandom_range(0, 7) != 0)
                a = $signed(32'($urandom_range(0, 1 << 19))) - (32'sd1 << 18);
            send_request(kind, a, b, ex, tsel);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.kind         <= fpc_pkg::KIND_ADD;
        req_if.operand_a    <= '0;
        req_if.operand_b    <= '0;
        req_if.exponent     <= '0;
        req_if.trig_select  <= fpc_pkg::TRIG_NONE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_add_sub();
        test_mul_div();
        test_power();
        test_trig();
        test_invalid();
        test_random(267);

        req_if.valid <= 1'b0;
        // drain outstanding words, then wait for strays
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (errors == 0 && answers_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
